FILE: src/sd64_pkg.sv
`default_nettype none

package sd64_pkg;

    localparam int HALF_W = 32;
    localparam int QUO_W  = 2 * HALF_W;
    localparam int CNT_W  = $clog2(QUO_W);

    // sign bit of a 32-bit word
    localparam logic [HALF_W-1:0] SIGN_BIT32 = 32'h8000_0000;

    localparam logic CMD_UNSIGNED = 1'b0;
    localparam logic CMD_SIGNED   = 1'b1;

    typedef struct packed {
        logic [HALF_W-1:0] rem;
        logic              qbit;
    } t_step_res;

endpackage

`default_nettype wire

FILE: src/sd64_step.sv
`default_nettype none

// One restoring division step: shift a bit into the partial remainder,
// subtract the divisor when it fits.
module sd64_step (
    input  wire logic [sd64_pkg::HALF_W-1:0] i_rem,
    input  wire logic                        i_bit,
    input  wire logic [sd64_pkg::HALF_W-1:0] i_den,
    output sd64_pkg::t_step_res              o_res
);
    import sd64_pkg::*;

    logic [HALF_W:0] trial;
    logic [HALF_W:0] den_ext;
    logic [HALF_W:0] diff;
    logic            fits;

    assign trial   = {i_rem, i_bit};
    assign den_ext = {1'b0, i_den};
    assign diff    = trial - den_ext;
    assign fits    = (trial >= den_ext);

    always_comb begin
        o_res.qbit = fits;
        o_res.rem  = fits ? diff[HALF_W-1:0] : trial[HALF_W-1:0];
    end

endmodule

`default_nettype wire

FILE: src/sd64_neg.sv
`default_nettype none

// Conditional two's complement negate, shared by entry and exit sign fixup.
module sd64_neg (
    input  wire logic                       i_en,
    input  wire logic [sd64_pkg::QUO_W-1:0] i_val,
    output logic      [sd64_pkg::QUO_W-1:0] o_val
);
    import sd64_pkg::*;

    assign o_val = i_en ? (QUO_W'(0) - i_val) : i_val;

endmodule

`default_nettype wire

FILE: src/signed_divide_64_by_32_core.sv
`default_nettype none

// 64-by-32 restoring divider, unsigned or signed, quotient only.
//
// Input channel: i_valid / o_stall carries one request (command, dividend
// halves, divisor). A request is taken on a rising edge with i_valid high
// and o_stall low. Output channel: o_valid / i_stall carries the quotient.
//
// Sequence: a request, once taken, gets sign fixup on the operands (PREP),
// then the bit loop (DIV) forms the 64 quotient bits one at a time through
// the shared step unit, then sign fixup on the quotient (FIX). The block
// holds one request at a time; o_stall is high from acceptance until the
// quotient is moved into the output register, so no new request is taken
// before then.
//
// The quotient sits in an output register; the next request is accepted
// while it waits. If the receiver stalls and the register is still full
// when the next quotient is ready, the sequencer holds in its final state.
//
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the output register. A zero divisor gives a zero quotient; signed
// overflow wraps to 64 bits.
module signed_divide_64_by_32_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_stall,
    input  wire logic                        i_command,
    input  wire logic [sd64_pkg::HALF_W-1:0] i_dividend_high,
    input  wire logic [sd64_pkg::HALF_W-1:0] i_dividend_low,
    input  wire logic [sd64_pkg::HALF_W-1:0] i_divisor_word,
    output logic                             o_valid,
    input  wire logic                        i_stall,
    output logic      [sd64_pkg::HALF_W-1:0] o_quotient_high,
    output logic      [sd64_pkg::HALF_W-1:0] o_quotient_low
);
    import sd64_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIX  = 2'd3;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

    logic [1:0]        r_state, n_state;
    logic              r_ovalid, n_ovalid;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // datapath: r_num holds the dividend, shifts left, and fills with
    // quotient bits from the bottom
    logic              r_cmd, n_cmd;
    logic [QUO_W-1:0]  r_num, n_num;
    logic [HALF_W-1:0] r_den, n_den;
    logic [HALF_W-1:0] r_rem, n_rem;
    logic              r_neg, n_neg;
    logic              r_dz, n_dz;
    logic [QUO_W-1:0]  r_quo, n_quo;

    logic              in_take;
    logic              out_free;
    logic              neg_en;
    logic [QUO_W-1:0]  neg_out;
    logic              num_neg;
    logic              den_neg;
    t_step_res         step;

    assign o_stall  = (r_state != ST_IDLE);
    assign in_take  = i_valid && !o_stall;
    assign out_free = !r_ovalid || !i_stall;

    assign num_neg = (r_cmd == CMD_SIGNED) && ((r_num[QUO_W-1:HALF_W] & SIGN_BIT32) != '0);
    assign den_neg = (r_cmd == CMD_SIGNED) && ((r_den & SIGN_BIT32) != '0);

    // entry: magnitude of dividend; exit: negate quotient
    assign neg_en = (r_state == ST_FIX) ? r_neg : num_neg;

    sd64_neg u_neg (
        .i_en  (neg_en),
        .i_val (r_num),
        .o_val (neg_out)
    );

    sd64_step u_step (
        .i_rem (r_rem),
        .i_bit (r_num[QUO_W-1]),
        .i_den (r_den),
        .o_res (step)
    );

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && i_stall;
        n_cnt    = r_cnt;
        n_cmd    = r_cmd;
        n_num    = r_num;
        n_den    = r_den;
        n_rem    = r_rem;
        n_neg    = r_neg;
        n_dz     = r_dz;
        n_quo    = r_quo;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_cmd   = i_command;
                    n_num   = {i_dividend_high, i_dividend_low};
                    n_den   = i_divisor_word;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_num   = neg_out;
                n_den   = den_neg ? (HALF_W'(0) - r_den) : r_den;
                n_neg   = num_neg ^ den_neg;
                n_dz    = (r_den == '0);
                n_rem   = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_rem = step.rem;
                n_num = {r_num[QUO_W-2:0], step.qbit};
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                if (out_free) begin
                    n_quo    = r_dz ? '0 : neg_out;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
        r_neg <= n_neg;
        r_dz  <= n_dz;
        r_quo <= n_quo;
    end

    assign o_valid         = r_ovalid;
    assign o_quotient_high = r_quo[QUO_W-1:HALF_W];
    assign o_quotient_low  = r_quo[HALF_W-1:0];

`ifndef NO_ASSERTIONS
    a_take_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> (r_state == ST_PREP))
        else $error("accepted request did not enter operand fixup");

    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt != CNT_LAST) |=> (r_state == ST_DIV))
        else $error("bit loop left early");

    a_out_from_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == ST_FIX))
        else $error("quotient appeared without exit fixup");

    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIX && out_free && r_dz)
            |=> (o_quotient_high == '0 && o_quotient_low == '0))
        else $error("zero divisor gave nonzero quotient");
`endif

endmodule

`default_nettype wire
